/* src/led_bps_pkg.sv */
// Shared types and constants for the LED blink pattern sequencer.
// No dependencies; every other file in src imports this package.
package led_bps_pkg;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_SET  = 2'd1,
    CMD_STOP = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_SCHEDULE = 3'd1,
    MODE_TRACE    = 3'd2,
    MODE_LOCK     = 3'd3,
    MODE_OPEN     = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    COLOR_DARK  = 2'd0,
    COLOR_RED   = 2'd1,
    COLOR_GREEN = 2'd2,
    COLOR_BLUE  = 2'd3
  } color_t;

  typedef enum logic [1:0] {
    CFG_SCHEDULE = 2'd0,
    CFG_TRACE    = 2'd1,
    CFG_LOCK     = 2'd2,
    CFG_OPEN     = 2'd3
  } cfg_idx_t;

  localparam logic [7:0] SCHEDULE_HALF_RST = 8'd200;
  localparam logic [7:0] TRACE_HALF_RST    = 8'd100;
  localparam logic [7:0] LOCK_HALF_RST     = 8'd50;
  localparam logic [7:0] OPEN_HALF_RST     = 8'd50;

  localparam logic [7:0] COUNT_MAX      = 8'hFF;
  localparam logic [2:0] SCHEDULE_STEPS = 3'd4;
  localparam logic [3:0] TRACE_LAST     = 4'd5;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] new_mode;
  } item_t;

  typedef struct packed {
    logic [7:0] schedule_half;
    logic [7:0] trace_half;
    logic [7:0] lock_half;
    logic [7:0] open_half;
  } limits_t;

  typedef struct packed {
    logic       en;
    logic [7:0] count;
    mode_t      mode;
    logic [1:0] sched_step;
    logic [2:0] trace_step;
    color_t     color;
  } seq_state_t;

endpackage

/* src/led_bps_in_stage.sv */
// Input register of the sequencer: holds one item until the step logic takes it.
// Depends on led_bps_pkg (item_t).
module led_bps_in_stage
  import led_bps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [2:0] in_new_mode,
  input  logic       advance,
  output logic       s1_valid,
  output item_t      s1_item
);

  logic  valid_r;
  item_t item_r;

  // Take a new item whenever the slot is empty or drains this cycle.
  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.command  <= in_command;
      item_r.new_mode <= in_new_mode;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

/* src/led_bps_step.sv */
// Next-state logic of the sequencer for one item: tick, set mode or stop.
// Depends on led_bps_pkg (item_t, limits_t, seq_state_t, codes).
module led_bps_step
  import led_bps_pkg::*;
(
  input  item_t      item,
  input  limits_t    limits,
  input  seq_state_t cur,
  output seq_state_t nxt
);

  logic [7:0] limit;
  logic [7:0] count_inc;
  logic [2:0] sched_s;
  logic [3:0] trace_s;

  always_comb begin
    case (cur.mode)
      MODE_SCHEDULE: limit = limits.schedule_half;
      MODE_TRACE:    limit = limits.trace_half;
      MODE_LOCK:     limit = limits.lock_half;
      MODE_OPEN:     limit = limits.open_half;
      default:       limit = 8'd0;
    endcase
  end

  // Saturate the count at its top value.
  assign count_inc = (cur.count == COUNT_MAX) ? cur.count : cur.count + 8'd1;
  assign sched_s   = {1'b0, cur.sched_step} + 3'd1;
  assign trace_s   = {1'b0, cur.trace_step} + 4'd1;

  always_comb begin
    nxt = cur;
    case (item.command)
      CMD_TICK: begin
        if (!cur.en) begin
          nxt.count = 8'd0;
        end else if (count_inc >= limit) begin
          nxt.count = 8'd0;
          case (cur.mode)
            MODE_SCHEDULE: begin
              if (sched_s == 3'd1) begin
                nxt.color = COLOR_DARK;
              end else if (sched_s == SCHEDULE_STEPS) begin
                nxt.color = COLOR_RED;
              end
              nxt.sched_step = sched_s[1:0];
            end
            MODE_TRACE: begin
              if (trace_s == 4'd1 || trace_s == 4'd3) begin
                nxt.color      = COLOR_DARK;
                nxt.trace_step = trace_s[2:0];
              end else if (trace_s == 4'd2 || trace_s == 4'd4) begin
                nxt.color      = COLOR_BLUE;
                nxt.trace_step = trace_s[2:0];
              end else if (trace_s == TRACE_LAST) begin
                nxt.en         = 1'b0;
                nxt.color      = COLOR_DARK;
                nxt.mode       = MODE_OFF;
                nxt.trace_step = 3'd0;
              end else begin
                nxt.trace_step = trace_s[2:0];
              end
            end
            MODE_LOCK, MODE_OPEN: begin
              nxt.en    = 1'b0;
              nxt.color = COLOR_DARK;
              nxt.mode  = MODE_OFF;
            end
            default: ;
          endcase
        end else begin
          nxt.count = count_inc;
        end
      end
      CMD_SET: begin
        if (item.new_mode <= MODE_OPEN) begin
          nxt.count = 8'd0;
          nxt.mode  = mode_t'(item.new_mode);
          case (item.new_mode)
            MODE_OFF: begin
              nxt.color = COLOR_DARK;
            end
            MODE_SCHEDULE: begin
              nxt.en         = 1'b1;
              nxt.sched_step = 2'd0;
              nxt.color      = COLOR_RED;
            end
            MODE_TRACE: begin
              nxt.en         = 1'b1;
              nxt.trace_step = 3'd0;
              nxt.color      = COLOR_BLUE;
            end
            MODE_LOCK: begin
              nxt.en    = 1'b1;
              nxt.color = COLOR_BLUE;
            end
            default: begin
              nxt.en    = 1'b1;
              nxt.color = COLOR_GREEN;
            end
          endcase
        end
      end
      CMD_STOP: begin
        nxt.en    = 1'b0;
        nxt.color = COLOR_DARK;
        nxt.mode  = MODE_OFF;
        nxt.count = 8'd0;
      end
      default: ;
    endcase
  end

endmodule

/* src/led_blink_pattern_sequencer_core.sv */
// Top level of the LED blink pattern sequencer: config registers, state/result
// register and handshakes. Depends on led_bps_pkg, led_bps_in_stage, led_bps_step.
//
//   channel | ports                                    | role
//   --------+------------------------------------------+-----------------------------
//   in      | in_valid in_ready in_command in_new_mode | tick, set mode, stop items
//   out     | out_valid out_ready out_led_color        | one result per item
//           | out_current_mode out_blinking            |
//   cfg     | cfg_we cfg_index cfg_wdata               | half-period registers 0..3
//
// An item waits in the input register, then the step logic updates the sequencer
// state, which is itself the result register.
// Throughput is one item per cycle; it is set by the single compare-and-update
// in the step logic between input and state registers, while out_ready is high.
// Reset (synchronous, active low) empties both stages, clears the state to off and
// dark, and loads the half-period registers with 200, 100, 50 and 50 ticks.
// A stalled result holds the state; one more item waits in the input register.
module led_blink_pattern_sequencer_core
  import led_bps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [2:0] in_new_mode,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_led_color,
  output logic [2:0] out_current_mode,
  output logic       out_blinking,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  limits_t    limits_r;
  seq_state_t state_r;
  seq_state_t state_nxt;
  logic       out_valid_r;
  logic       s1_valid;
  item_t      s1_item;
  logic       advance;

  // Half-period registers; the user must write them only while idle, unenforced here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.schedule_half <= SCHEDULE_HALF_RST;
      limits_r.trace_half    <= TRACE_HALF_RST;
      limits_r.lock_half     <= LOCK_HALF_RST;
      limits_r.open_half     <= OPEN_HALF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCHEDULE: limits_r.schedule_half <= cfg_wdata;
        CFG_TRACE:    limits_r.trace_half    <= cfg_wdata;
        CFG_LOCK:     limits_r.lock_half     <= cfg_wdata;
        CFG_OPEN:     limits_r.open_half     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the held item when the result slot is free or being taken.
  assign advance = s1_valid && (!out_valid_r || out_ready);

  led_bps_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_new_mode(in_new_mode),
    .advance    (advance),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item)
  );

  led_bps_step u_step (
    .item  (s1_item),
    .limits(limits_r),
    .cur   (state_r),
    .nxt   (state_nxt)
  );

  // The state changes only when a result is loaded, so it doubles as the
  // output register: the shown fields are the state after the last item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.en         <= 1'b0;
      state_r.count      <= 8'd0;
      state_r.mode       <= MODE_OFF;
      state_r.sched_step <= 2'd0;
      state_r.trace_step <= 3'd0;
      state_r.color      <= COLOR_DARK;
      out_valid_r        <= 1'b0;
    end else if (advance) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_led_color    = state_r.color;
  assign out_current_mode = state_r.mode;
  assign out_blinking     = state_r.en;

`ifndef SYNTHESIS
  // Off mode always shows a dark LED.
  a_off_is_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode == MODE_OFF) |-> (state_r.color == COLOR_DARK))
    else $error("off mode with LED lit");

  // Any active mode keeps the counter running.
  a_mode_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode != MODE_OFF) |-> state_r.en)
    else $error("active mode with counter disabled");

  // With both stages full and the result stalled, no item may enter.
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && out_valid_r && !out_ready) |-> !in_ready)
    else $error("item accepted while pipeline full and stalled");

  // A stalled result keeps the state unchanged into the next cycle.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(state_r))
    else $error("state changed under a stalled result");
`endif

endmodule
